@@ rtl/pcfl_pkg.sv @@
// ----------------------------------------------------------------------------
// pcfl_pkg
// Shared types and constants of the palette color fade lookup unit.
// ----------------------------------------------------------------------------
package pcfl_pkg;

  localparam int TABLE_ENTRIES = 32;
  localparam int INDEX_W       = 5;
  localparam int CHAN_W        = 5;
  localparam int MAX_ADDR_W    = 8;
  localparam int WORD_W        = 16;
  localparam int QUEUE_DEPTH   = 4;

  // Input tdata layout
  localparam int SRC_LSB      = 0;
  localparam int LVL_LSB      = 16;
  localparam int LCH_LSB      = 18;
  localparam int LIDX_LSB     = 20;
  localparam int LWORD_LSB    = 25;
  localparam int IN_TDATA_W   = 48;
  localparam int OUT_TDATA_W  = 16;

  // Configuration registers
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;
  localparam logic [CFG_IDX_W-1:0] CFG_FADE_INTENSITY   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FADE_COLOR       = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BRIGHTNESS_LEVEL = 2'd2;

  localparam logic OP_CONVERT = 1'b0;
  localparam logic OP_LOAD    = 1'b1;

  localparam logic [1:0] CH_RED   = 2'd0;
  localparam logic [1:0] CH_GREEN = 2'd1;
  localparam logic [1:0] CH_BLUE  = 2'd2;

  localparam logic [8:0]  MAX_INTENSITY = 9'd256;
  localparam logic [10:0] FULL_SCALE    = 11'h400;

  typedef struct packed {
    logic                  is_load;
    logic [1:0]            chan;
    logic [MAX_ADDR_W-1:0] addr_r;
    logic [MAX_ADDR_W-1:0] addr_g;
    logic [MAX_ADDR_W-1:0] addr_b;
    logic [WORD_W-1:0]     word;
  } pcfl_cmd_t;

endpackage

@@ rtl/pcfl_front.sv @@
// ----------------------------------------------------------------------------
// pcfl_front
// Accepts input transactions, drops invalid loads, fades the color channels
// into table addresses and hands one command per kept item to the queue.
// ----------------------------------------------------------------------------
module pcfl_front #(
  parameter int BRIGHTNESS_LEVELS = 3
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [pcfl_pkg::IN_TDATA_W-1:0]     in_tdata,
  input  logic                                in_tuser,
  input  logic [8:0]                          fade_intensity,
  input  logic [7:0]                          fade_color,
  input  logic [1:0]                          brightness_level,
  input  logic                                q_full,
  output logic                                q_push,
  output pcfl_pkg::pcfl_cmd_t                 q_cmd
);
  import pcfl_pkg::*;

  localparam int ADDR_W = $clog2(BRIGHTNESS_LEVELS * TABLE_ENTRIES);

  logic [10:0]          factor_r;
  logic [16:0]          bias_r;
  logic [8:0]           intensity;
  logic                 f_v_r;
  pcfl_cmd_t            f_cmd_r;
  pcfl_cmd_t            cmd_nxt;
  logic                 keep;
  logic                 accept;
  logic [15:0]          src;
  logic [1:0]           ld_level;
  logic [1:0]           ld_chan;
  logic [INDEX_W-1:0]   ld_idx;
  logic [1:0]           level;
  logic [INDEX_W-1:0]   idx_r;
  logic [INDEX_W-1:0]   idx_g;
  logic [INDEX_W-1:0]   idx_b;

  function automatic logic [INDEX_W-1:0] fade_index(input logic [CHAN_W-1:0] c,
                                                    input logic [10:0] factor,
                                                    input logic [16:0] bias);
    logic [16:0] sum;
    sum = 17'(factor * {c, 1'b0}) + bias;
    return sum[15:11];
  endfunction

  function automatic logic [MAX_ADDR_W-1:0] slot(input logic [1:0] lvl,
                                                 input logic [INDEX_W-1:0] idx);
    logic [ADDR_W-1:0] a;
    a = ADDR_W'({1'b0, lvl, idx});
    return MAX_ADDR_W'(a);
  endfunction

  assign intensity = (fade_intensity > MAX_INTENSITY) ? MAX_INTENSITY : fade_intensity;

  always_ff @(posedge clk) begin
    factor_r <= FULL_SCALE - {intensity, 2'b00};
    bias_r   <= 17'(intensity * fade_color);
  end

  assign src      = in_tdata[SRC_LSB +: 16];
  assign ld_level = in_tdata[LVL_LSB +: 2];
  assign ld_chan  = in_tdata[LCH_LSB +: 2];
  assign ld_idx   = in_tdata[LIDX_LSB +: INDEX_W];
  assign level    = (32'(brightness_level) >= BRIGHTNESS_LEVELS) ? 2'd0 : brightness_level;

  assign idx_r = fade_index(src[4:0],   factor_r, bias_r);
  assign idx_g = fade_index(src[9:5],   factor_r, bias_r);
  assign idx_b = fade_index(src[14:10], factor_r, bias_r);

  always_comb begin
    cmd_nxt.is_load = (in_tuser == OP_LOAD);
    cmd_nxt.chan    = ld_chan;
    cmd_nxt.word    = in_tdata[LWORD_LSB +: WORD_W];
    if (in_tuser == OP_LOAD) begin
      cmd_nxt.addr_r = slot(ld_level, ld_idx);
      cmd_nxt.addr_g = '0;
      cmd_nxt.addr_b = '0;
      keep = (32'(ld_level) < BRIGHTNESS_LEVELS) && (ld_chan != 2'd3);
    end else begin
      cmd_nxt.addr_r = slot(level, idx_r);
      cmd_nxt.addr_g = slot(level, idx_g);
      cmd_nxt.addr_b = slot(level, idx_b);
      keep = 1'b1;
    end
  end

  assign q_push    = f_v_r && !q_full;
  assign in_tready = !f_v_r || !q_full;
  assign accept    = in_tvalid && in_tready;
  assign q_cmd     = f_cmd_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_v_r <= 1'b0;
    end else if (in_tready) begin
      f_v_r <= accept && keep;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready) begin
      f_cmd_r <= cmd_nxt;
    end
  end

  a_hold_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    f_v_r && q_full |=> f_v_r && $stable(f_cmd_r))
    else $error("front command lost while queue full");

endmodule

@@ rtl/pcfl_queue.sv @@
// ----------------------------------------------------------------------------
// pcfl_queue
// Short command queue between the front and the back.
// ----------------------------------------------------------------------------
module pcfl_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  pcfl_pkg::pcfl_cmd_t push_cmd,
  output logic                full,
  input  logic                pop,
  output logic                not_empty,
  output pcfl_pkg::pcfl_cmd_t head
);
  import pcfl_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);

  pcfl_cmd_t        store [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [PTR_W:0]   count_r;

  assign full      = (count_r == (PTR_W+1)'(QUEUE_DEPTH));
  assign not_empty = (count_r != '0);
  assign head      = store[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      store[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      count_r <= count_r + (PTR_W+1)'(push) - (PTR_W+1)'(pop);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full)
    else $error("queue overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> not_empty)
    else $error("queue underflow");

endmodule

@@ rtl/pcfl_back.sv @@
// ----------------------------------------------------------------------------
// pcfl_back
// Holds the channel tables, writes loads, reads the three words of a
// convert and registers their OR on the output channel.
// ----------------------------------------------------------------------------
module pcfl_back #(
  parameter int BRIGHTNESS_LEVELS = 3
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               q_not_empty,
  input  pcfl_pkg::pcfl_cmd_t                q_head,
  output logic                               q_pop,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [pcfl_pkg::OUT_TDATA_W-1:0]   out_tdata
);
  import pcfl_pkg::*;

  localparam int DEPTH  = BRIGHTNESS_LEVELS * TABLE_ENTRIES;
  localparam int ADDR_W = $clog2(DEPTH);

  logic [WORD_W-1:0] mem_r [DEPTH];
  logic [WORD_W-1:0] mem_g [DEPTH];
  logic [WORD_W-1:0] mem_b [DEPTH];
  logic [WORD_W-1:0] rd_r_r;
  logic [WORD_W-1:0] rd_g_r;
  logic [WORD_W-1:0] rd_b_r;
  logic              s1_v_r;
  logic              s1_move;
  logic              s1_free;
  logic              wr_en;
  logic              rd_en;
  logic              out_tvalid_r;
  logic [WORD_W-1:0] out_tdata_r;
  logic [ADDR_W-1:0] a_r;
  logic [ADDR_W-1:0] a_g;
  logic [ADDR_W-1:0] a_b;

  assign a_r = q_head.addr_r[ADDR_W-1:0];
  assign a_g = q_head.addr_g[ADDR_W-1:0];
  assign a_b = q_head.addr_b[ADDR_W-1:0];

  assign s1_move = s1_v_r && (!out_tvalid_r || out_tready);
  assign s1_free = !s1_v_r || s1_move;
  assign q_pop   = q_not_empty && (q_head.is_load || s1_free);
  assign wr_en   = q_pop && q_head.is_load;
  assign rd_en   = q_pop && !q_head.is_load;

  always_ff @(posedge clk) begin
    if (wr_en && q_head.chan == CH_RED) begin
      mem_r[a_r] <= q_head.word;
    end
    if (rd_en) begin
      rd_r_r <= mem_r[a_r];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en && q_head.chan == CH_GREEN) begin
      mem_g[a_r] <= q_head.word;
    end
    if (rd_en) begin
      rd_g_r <= mem_g[a_g];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en && q_head.chan == CH_BLUE) begin
      mem_b[a_r] <= q_head.word;
    end
    if (rd_en) begin
      rd_b_r <= mem_b[a_b];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r       <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      if (s1_free) begin
        s1_v_r <= rd_en;
      end
      if (s1_move) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      out_tdata_r <= rd_r_r | rd_g_r | rd_b_r;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  a_read_lands: assert property (@(posedge clk) disable iff (!rst_n)
    rd_en |=> s1_v_r)
    else $error("table read without pending result");

  a_stall_holds_read: assert property (@(posedge clk) disable iff (!rst_n)
    s1_v_r && !s1_move |=> s1_v_r && $stable(rd_r_r) && $stable(rd_g_r) && $stable(rd_b_r))
    else $error("pending read data overwritten");

endmodule

@@ rtl/palette_color_fade_lut_unit.sv @@
// ----------------------------------------------------------------------------
// palette_color_fade_lut_unit
// Fades 15-bit palette colors toward a target level and maps each channel
// through a per-level lookup table.
//
// in_*  : one transaction per item. in_tuser is the op (0 convert, 1 load).
//         A convert gives one transaction on out_*, a load gives none.
// out_* : faded_color, the OR of the red, green and blue table words.
// cfg_* : write fade_intensity (0), fade_color (1), brightness_level (2)
//         while the unit is idle; indexes beyond these are ignored.
// Throughput is one item per cycle while out_tready is high: each channel
// table has its own memory with one write and one read port, so all three
// lookups of a convert issue in the same cycle. An item passes the front,
// queue, read and output registers. Reset empties the front register, the
// queue and the output register; tables are not cleared and must be loaded
// before they are read. While out_tready is low, up to the queue depth plus
// three items are held before in_tready falls; nothing is dropped.
// ----------------------------------------------------------------------------
module palette_color_fade_lut_unit #(
  parameter int BRIGHTNESS_LEVELS = 3
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // source_color[15:0], load_level[17:16], load_channel[19:18],
  // load_index[24:20], load_word[40:25], zero[47:41]
  input  logic [pcfl_pkg::IN_TDATA_W-1:0]   in_tdata,
  // op[0]
  input  logic                              in_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // faded_color[15:0]
  output logic [pcfl_pkg::OUT_TDATA_W-1:0]  out_tdata,
  input  logic                              cfg_we,
  input  logic [pcfl_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [pcfl_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import pcfl_pkg::*;

  logic [8:0] fade_intensity_r;
  logic [7:0] fade_color_r;
  logic [1:0] brightness_level_r;
  logic       q_full;
  logic       q_push;
  logic       q_pop;
  logic       q_not_empty;
  pcfl_cmd_t  q_cmd;
  pcfl_cmd_t  q_head;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fade_intensity_r   <= '0;
      fade_color_r       <= '0;
      brightness_level_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_FADE_INTENSITY:   fade_intensity_r   <= cfg_wdata;
        CFG_FADE_COLOR:       fade_color_r       <= cfg_wdata[7:0];
        CFG_BRIGHTNESS_LEVEL: brightness_level_r <= cfg_wdata[1:0];
        default: ;
      endcase
    end
  end

  pcfl_front #(
    .BRIGHTNESS_LEVELS(BRIGHTNESS_LEVELS)
  ) u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_tvalid        (in_tvalid),
    .in_tready        (in_tready),
    .in_tdata         (in_tdata),
    .in_tuser         (in_tuser),
    .fade_intensity   (fade_intensity_r),
    .fade_color       (fade_color_r),
    .brightness_level (brightness_level_r),
    .q_full           (q_full),
    .q_push           (q_push),
    .q_cmd            (q_cmd)
  );

  pcfl_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_cmd  (q_cmd),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head      (q_head)
  );

  pcfl_back #(
    .BRIGHTNESS_LEVELS(BRIGHTNESS_LEVELS)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_not_empty (q_not_empty),
    .q_head      (q_head),
    .q_pop       (q_pop),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata)
  );

endmodule

@@ tb/sv/palette_color_fade_lut_unit_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// palette_color_fade_lut_unit_tb
// Loads every lookup table word, then streams convert and load transactions
// through the unit under a series of fade settings. A shadow copy of the
// tables and registers predicts each faded color, and every output
// transaction is checked in order. The sender bursts with random gaps, the
// receiver stalls on its own pattern, and one long output hold backs the
// unit up into its input.
// ----------------------------------------------------------------------------
module palette_color_fade_lut_unit_tb;
  import pcfl_pkg::*;

  localparam int LEVELS = 3;
  localparam int DRAIN_CYCLES = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  typedef enum int {RX_STEADY, RX_COIN, RX_SPARSE, RX_PERIODIC} rx_mode_t;

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic                   in_tuser;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   cfg_we;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_wdata;

  logic [WORD_W-1:0] lut_shadow [LEVELS][3][TABLE_ENTRIES];
  logic [8:0]        fade_intensity_q;
  logic [7:0]        fade_color_q;
  logic [1:0]        brightness_q;
  logic [WORD_W-1:0] expected_colors [$];

  int error_count;
  int convert_count;
  int load_count;
  int setting_count;
  int in_stall_cycles;
  int burst_left;
  int gap_max;
  int hold_request;

  palette_color_fade_lut_unit #(.BRIGHTNESS_LEVELS(LEVELS)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic logic [WORD_W-1:0] fade_lookup(input logic [15:0] color);
    int unsigned sat;
    int unsigned factor;
    int unsigned bias;
    int unsigned lvl;
    int unsigned idx;
    logic [WORD_W-1:0] word;
    sat    = (fade_intensity_q > MAX_INTENSITY) ? MAX_INTENSITY : fade_intensity_q;
    factor = FULL_SCALE - 4 * sat;
    bias   = sat * fade_color_q;
    lvl    = (brightness_q >= LEVELS) ? 0 : brightness_q;
    word   = '0;
    for (int ch = 0; ch < 3; ch++) begin
      idx  = (((factor * {color[5*ch +: 5], 1'b0} + bias) >> 10) & 'h3E) >> 1;
      word = word | lut_shadow[lvl][ch][idx];
    end
    return word;
  endfunction

  function automatic logic [IN_TDATA_W-1:0] pack_convert(input logic [15:0] color);
    logic [IN_TDATA_W-1:0] data;
    data = '0;
    data[SRC_LSB +: 16] = color;
    return data;
  endfunction

  function automatic logic [IN_TDATA_W-1:0] pack_load(input logic [1:0] lvl,
      input logic [1:0] ch, input logic [4:0] idx, input logic [15:0] word);
    logic [IN_TDATA_W-1:0] data;
    data = '0;
    data[LVL_LSB +: 2]   = lvl;
    data[LCH_LSB +: 2]   = ch;
    data[LIDX_LSB +: 5]  = idx;
    data[LWORD_LSB +: 16] = word;
    return data;
  endfunction

  // Called at a falling edge; returns at a falling edge.
  task automatic send_item(input logic op, input logic [IN_TDATA_W-1:0] data);
    int gap;
    logic [1:0] lvl;
    logic [1:0] ch;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = $urandom_range(0, gap_max);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tdata  <= data;
    in_tuser  <= op;
    do @(posedge clk); while (!in_tready);
    if (op == OP_LOAD) begin
      lvl = data[LVL_LSB +: 2];
      ch  = data[LCH_LSB +: 2];
      load_count++;
      if (lvl < LEVELS && ch <= CH_BLUE)
        lut_shadow[lvl][ch][data[LIDX_LSB +: 5]] = data[LWORD_LSB +: 16];
    end else begin
      convert_count++;
      expected_colors.push_back(fade_lookup(data[SRC_LSB +: 16]));
    end
    @(negedge clk);
  endtask

  task automatic wait_drain();
    in_tvalid  <= 1'b0;
    burst_left = 0;
    while (expected_colors.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] index,
      input logic [CFG_DATA_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= index;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
    case (index)
      CFG_FADE_INTENSITY:   fade_intensity_q = value[8:0];
      CFG_FADE_COLOR:       fade_color_q     = value[7:0];
      CFG_BRIGHTNESS_LEVEL: brightness_q     = value[1:0];
      default: ;
    endcase
  endtask

  task automatic set_fade(input int intensity, input int color, input int level);
    wait_drain();
    write_reg(CFG_FADE_INTENSITY, CFG_DATA_W'(intensity));
    write_reg(CFG_FADE_COLOR, CFG_DATA_W'(color));
    write_reg(CFG_BRIGHTNESS_LEVEL, CFG_DATA_W'(level));
    setting_count++;
  endtask

  task automatic send_random_item();
    logic [1:0] lvl;
    logic [1:0] ch;
    if ($urandom_range(0, 99) < 80) begin
      send_item(OP_CONVERT, pack_convert(16'($urandom_range(0, 65535))));
    end else begin
      lvl = ($urandom_range(0, 9) != 0) ? 2'($urandom_range(0, LEVELS - 1)) : 2'd3;
      ch  = ($urandom_range(0, 9) != 0) ? 2'($urandom_range(0, 2)) : 2'd3;
      send_item(OP_LOAD, pack_load(lvl, ch, 5'($urandom_range(0, 31)),
                                   16'($urandom_range(0, 65535))));
    end
  endtask

  task automatic test_table_fill();
    for (int lvl = 0; lvl < LEVELS; lvl++)
      for (int ch = 0; ch < 3; ch++)
        for (int idx = 0; idx < TABLE_ENTRIES; idx++)
          send_item(OP_LOAD, pack_load(2'(lvl), 2'(ch), 5'(idx),
                                       16'($urandom_range(0, 65535))));
  endtask

  task automatic test_directed_cases();
    gap_max = 0;
    set_fade(0, 0, 0);
    send_item(OP_CONVERT, pack_convert(16'h0000));
    send_item(OP_CONVERT, pack_convert(16'h7FFF));
    send_item(OP_CONVERT, pack_convert(16'hFFFF));
    send_item(OP_CONVERT, pack_convert(16'h8000));
    send_item(OP_CONVERT, pack_convert(16'h001F));
    send_item(OP_CONVERT, pack_convert(16'h03E0));
    send_item(OP_CONVERT, pack_convert(16'h7C00));
    // reload an entry and read it back on the very next transaction
    send_item(OP_LOAD, pack_load(2'd0, CH_RED, 5'd5, 16'hA5A5));
    send_item(OP_CONVERT, pack_convert(16'h0005));
    // out-of-range loads must leave the tables alone
    send_item(OP_LOAD, pack_load(2'd3, CH_RED, 5'd0, 16'hFFFF));
    send_item(OP_LOAD, pack_load(2'd0, 2'd3, 5'd0, 16'hFFFF));
    send_item(OP_CONVERT, pack_convert(16'h0000));
    set_fade(MAX_INTENSITY, 'hF8, 1);
    send_item(OP_CONVERT, pack_convert(16'h7FFF));
    send_item(OP_CONVERT, pack_convert(16'h0000));
    set_fade('h1FF, 'h1FF, 2);
    send_item(OP_CONVERT, pack_convert(16'h1234));
    send_item(OP_CONVERT, pack_convert(16'hFFFF));
    set_fade(128, 'h80, 3);
    write_reg(CFG_UNUSED, 9'h1FF);
    send_item(OP_CONVERT, pack_convert(16'h5A5A));
    send_item(OP_CONVERT, pack_convert(16'h2525));
    gap_max = 6;
  endtask

  task automatic test_random_traffic();
    for (int k = 0; k < 6; k++) begin
      case (k)
        0: set_fade(0, 0, 0);
        1: set_fade(MAX_INTENSITY, 'hF8, 1);
        2: set_fade('h1FF, 'hFF, 2);
        3: set_fade($urandom_range(0, 256), $urandom_range(0, 255), 3);
        default: set_fade($urandom_range(0, 511), $urandom_range(0, 511),
                          $urandom_range(0, 511));
      endcase
      gap_max = (k % 2 == 1) ? 0 : 6;
      repeat (125) send_random_item();
    end
    gap_max = 6;
  endtask

  task automatic test_output_hold();
    set_fade($urandom_range(1, 255), $urandom_range(0, 255), $urandom_range(0, 2));
    hold_request = 120;
    repeat (2) @(negedge clk);
    gap_max = 0;
    repeat (60) send_item(OP_CONVERT, pack_convert(16'($urandom_range(0, 65535))));
    gap_max = 6;
  endtask

  // Receiver: ready pattern changes mode now and then; honors long hold requests.
  initial begin
    int hold;
    int mode_left;
    int phase;
    rx_mode_t rx_mode;
    out_tready = 1'b0;
    hold = 0;
    mode_left = 0;
    phase = 0;
    rx_mode = RX_STEADY;
    forever begin
      @(negedge clk);
      if (hold_request > 0) begin
        hold = hold_request;
        hold_request = 0;
      end
      if (hold > 0) begin
        hold--;
        out_tready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          rx_mode   = rx_mode_t'($urandom_range(0, 3));
          mode_left = $urandom_range(20, 200);
        end
        mode_left--;
        phase++;
        case (rx_mode)
          RX_STEADY:   out_tready <= 1'b1;
          RX_COIN:     out_tready <= 1'($urandom_range(0, 1));
          RX_SPARSE:   out_tready <= ($urandom_range(0, 9) == 0);
          RX_PERIODIC: out_tready <= (phase % 4 != 3);
          default:     out_tready <= 1'b1;
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && !in_tready)
        in_stall_cycles++;
      if (out_tvalid && out_tready) begin
        if (expected_colors.size() == 0) begin
          $error("faded_color: unexpected transaction, got %h", out_tdata);
          error_count++;
        end else begin
          if (out_tdata !== expected_colors[0]) begin
            $error("faded_color: expected %h, actual %h", expected_colors[0], out_tdata);
            error_count++;
          end
          void'(expected_colors.pop_front());
        end
      end
    end
  end

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = OP_CONVERT;
    cfg_we = 1'b0;
    cfg_index = CFG_FADE_INTENSITY;
    cfg_wdata = '0;
    fade_intensity_q = '0;
    fade_color_q = '0;
    brightness_q = '0;
    error_count = 0;
    convert_count = 0;
    load_count = 0;
    setting_count = 0;
    in_stall_cycles = 0;
    burst_left = 0;
    gap_max = 6;
    hold_request = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_table_fill();
    test_directed_cases();
    test_random_traffic();
    test_output_hold();
    wait_drain();

    $display("Checked %0d color conversions and %0d table loads over %0d fade settings;",
             convert_count, load_count, setting_count);
    $display("input held off for %0d cycles by output backpressure.", in_stall_cycles);
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/pcfl_pkg.sv
rtl/pcfl_front.sv
rtl/pcfl_queue.sv
rtl/pcfl_back.sv
rtl/palette_color_fade_lut_unit.sv
tb/sv/palette_color_fade_lut_unit_tb.sv
